@@ rtl/tptl_pkg.sv @@
// shared types and constants for the tlb / page table translator
// no dependencies; imported by the controller, datapath and top level
package tptl_pkg;

    // default sizes, handed down through top level parameters
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_COUNT_DEF = 256;
    localparam int OFFSET_BITS_DEF = 8;

    // fixed field widths
    localparam int VA_W    = 16;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int STAMP_W = 32;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_LOOKUP,
        OP_HIT_UPD,
        OP_PF_RD,
        OP_PF_USE,
        OP_VSCAN,
        OP_OWN_RD,
        OP_OWN_USE,
        OP_TSCAN,
        OP_REFILL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic page_big;
        logic tlb_match;
        logic page_resident;
        logic vscan_done;
        logic tscan_done;
    } dp_status_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LOOKUP,
        ST_HIT_UPD,
        ST_PF_RD,
        ST_PF_USE,
        ST_VSCAN,
        ST_OWN_RD,
        ST_OWN_USE,
        ST_TSCAN,
        ST_REFILL,
        ST_DONE
    } ctl_state_t;

endpackage

@@ rtl/tlb_page_table_lru_translator_unit.sv @@
// Address translator with a fully associative TLB, a page table and
// least-recently-used demand paging. One transaction at a time. A page number
// that is not below PAGE_COUNT is first reduced by repeated subtraction of
// PAGE_COUNT, and a finished result may wait on out_stall.
// The fault time is set by the victim search, which reads the frame stamp
// memory one frame per cycle, and the TLB refill search, one entry per cycle.
// No clearing pass is needed after reset. The result stays on the output
// until taken; the next transaction is accepted after that.
module tlb_page_table_lru_translator_unit #(
    parameter int TLB_ENTRIES = tptl_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tptl_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = tptl_pkg::FRAME_COUNT_DEF,
    parameter int OFFSET_BITS = tptl_pkg::OFFSET_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tptl_pkg::VA_W-1:0]    virtual_address,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tptl_pkg::VA_W-1:0]    physical_address,
    output logic [tptl_pkg::FRAME_W-1:0] frame_number,
    output logic                         tlb_hit,
    output logic                         page_fault,
    output logic [tptl_pkg::PAGE_W-1:0]  load_page
);
    import tptl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    tptl_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // storage and compare logic
    tptl_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .virtual_address  (virtual_address),
        .cmd              (cmd),
        .status           (status),
        .physical_address (physical_address),
        .frame_number     (frame_number),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .load_page        (load_page)
    );

endmodule

@@ rtl/tptl_ctl.sv @@
// controller state machine for the translator
// depends on tptl_pkg; drives datapath commands and the handshakes
module tptl_ctl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tptl_pkg::dp_status_t status,
    output tptl_pkg::dp_cmd_t    cmd
);
    import tptl_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.page_big)
                begin
                    cmd.op = OP_REDUCE;
                end
                else
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.op = OP_LOOKUP;
                if (status.tlb_match)
                begin
                    state_next = ST_HIT_UPD;
                end
                else if (status.page_resident)
                begin
                    state_next = ST_PF_RD;
                end
                else
                begin
                    state_next = ST_VSCAN;
                end
            end
            ST_HIT_UPD:
            begin
                cmd.op     = OP_HIT_UPD;
                state_next = ST_DONE;
            end
            ST_PF_RD:
            begin
                cmd.op     = OP_PF_RD;
                state_next = ST_PF_USE;
            end
            ST_PF_USE:
            begin
                cmd.op     = OP_PF_USE;
                state_next = ST_TSCAN;
            end
            ST_VSCAN:
            begin
                cmd.op = OP_VSCAN;
                if (status.vscan_done)
                begin
                    state_next = ST_OWN_RD;
                end
            end
            ST_OWN_RD:
            begin
                cmd.op     = OP_OWN_RD;
                state_next = ST_OWN_USE;
            end
            ST_OWN_USE:
            begin
                cmd.op     = OP_OWN_USE;
                state_next = ST_TSCAN;
            end
            ST_TSCAN:
            begin
                cmd.op = OP_TSCAN;
                if (status.tscan_done)
                begin
                    state_next = ST_REFILL;
                end
            end
            ST_REFILL:
            begin
                cmd.op     = OP_REFILL;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tptl_datapath.sv @@
// translator datapath: tlb registers, page table, frame owner and stamp memories
// depends on tptl_pkg; controlled by tptl_ctl through dp_cmd_t / dp_status_t
module tptl_datapath #(
    parameter int TLB_ENTRIES = tptl_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tptl_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = tptl_pkg::FRAME_COUNT_DEF,
    parameter int OFFSET_BITS = tptl_pkg::OFFSET_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tptl_pkg::VA_W-1:0]    virtual_address,
    input  tptl_pkg::dp_cmd_t            cmd,
    output tptl_pkg::dp_status_t         status,
    output logic [tptl_pkg::VA_W-1:0]    physical_address,
    output logic [tptl_pkg::FRAME_W-1:0] frame_number,
    output logic                         tlb_hit,
    output logic                         page_fault,
    output logic [tptl_pkg::PAGE_W-1:0]  load_page
);
    import tptl_pkg::*;

    localparam int TIW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int TCW = $clog2(TLB_ENTRIES + 1);
    localparam int PIW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FIW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int VCW = $clog2(FRAME_COUNT + 1);

    // transaction registers
    logic [OFFSET_BITS-1:0] off_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [FRAME_W-1:0]     frame_reg;
    logic                   hit_reg;
    logic                   fault_reg;
    logic [STAMP_W-1:0]     clk_reg;

    // tlb
    logic [PAGE_W-1:0]      tlb_page_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     tlb_frame_reg [TLB_ENTRIES];
    logic [STAMP_W-1:0]     tlb_stamp_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [TIW-1:0]         hidx_reg;
    logic [TCW-1:0]         tcnt_reg;
    logic [TIW-1:0]         tbest_idx_reg;
    logic [STAMP_W-1:0]     tbest_stamp_reg;

    // page table
    logic [PAGE_COUNT-1:0]  page_valid_reg;
    logic [FRAME_W-1:0]     pf_mem [PAGE_COUNT];
    logic [FRAME_W-1:0]     pf_rdata_reg;

    // frame owner and frame stamp
    logic [FRAME_COUNT-1:0] owner_valid_reg;
    logic [PAGE_W-1:0]      owner_mem [FRAME_COUNT];
    logic [PAGE_W-1:0]      own_rdata_reg;
    logic                   own_vld_reg;
    logic [FRAME_COUNT-1:0] fs_valid_reg;
    logic [STAMP_W-1:0]     fs_mem [FRAME_COUNT];
    logic [STAMP_W-1:0]     fs_rdata_reg;
    logic                   fs_vbit_reg;
    logic [VCW-1:0]         vcnt_reg;
    logic [FIW-1:0]         rd_idx_reg;
    logic                   rd_vld_reg;
    logic [FIW-1:0]         best_idx_reg;
    logic [STAMP_W-1:0]     best_stamp_reg;

    logic [VA_W-1:0]        va_sh;
    logic [PIW-1:0]         pidx;
    logic [FIW-1:0]         vidx;
    logic [TIW-1:0]         tidx;
    logic                   match;
    logic [TIW-1:0]         midx;
    logic [STAMP_W-1:0]     fs_eff;
    logic                   fs_we;
    logic [FIW-1:0]         fs_waddr;
    logic [31:0]            pa_wide;

    assign va_sh  = virtual_address >> OFFSET_BITS;
    assign pidx   = page_reg[PIW-1:0];
    assign vidx   = vcnt_reg[FIW-1:0];
    assign tidx   = tcnt_reg[TIW-1:0];
    assign fs_eff = fs_vbit_reg ? fs_rdata_reg : '0;

    // parallel tlb compare, lowest matching entry
    always_comb
    begin
        match = 1'b0;
        midx  = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page_reg))
            begin
                match = 1'b1;
                midx  = TIW'(i);
            end
        end
    end

    // frame stamp write port select
    always_comb
    begin
        fs_we    = 1'b0;
        fs_waddr = '0;
        case (cmd.op)
            OP_HIT_UPD:
            begin
                fs_we    = 1'b1;
                fs_waddr = frame_reg[FIW-1:0];
            end
            OP_PF_USE:
            begin
                fs_we    = 1'b1;
                fs_waddr = pf_rdata_reg[FIW-1:0];
            end
            OP_OWN_USE:
            begin
                fs_we    = 1'b1;
                fs_waddr = best_idx_reg;
            end
            default:
            begin
                fs_we = 1'b0;
            end
        endcase
    end

    // status to the controller
    assign status.page_big      = {1'b0, page_reg} >= (PAGE_W + 1)'(PAGE_COUNT);
    assign status.tlb_match     = match;
    assign status.page_resident = page_valid_reg[pidx];
    assign status.vscan_done    = (vcnt_reg == VCW'(FRAME_COUNT)) && !rd_vld_reg;
    assign status.tscan_done    = (tcnt_reg == TCW'(TLB_ENTRIES));

    // control state: valid bits, stamps, clock, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_reg         <= '0;
            tlb_valid_reg   <= '0;
            page_valid_reg  <= '0;
            owner_valid_reg <= '0;
            fs_valid_reg    <= '0;
            vcnt_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            tcnt_reg        <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tlb_stamp_reg[i] <= '0;
            end
        end
        else
        begin
            if (fs_we)
            begin
                fs_valid_reg[fs_waddr] <= 1'b1;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (clk_reg != '1)
                    begin
                        clk_reg <= clk_reg + 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    vcnt_reg   <= '0;
                    rd_vld_reg <= 1'b0;
                    tcnt_reg   <= '0;
                end
                OP_HIT_UPD:
                begin
                    tlb_stamp_reg[hidx_reg] <= clk_reg;
                end
                OP_VSCAN:
                begin
                    if (vcnt_reg != VCW'(FRAME_COUNT))
                    begin
                        vcnt_reg   <= vcnt_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_vld_reg <= 1'b0;
                    end
                end
                OP_OWN_USE:
                begin
                    // drop the evicted page's mapping and any tlb copy of it
                    if (own_vld_reg)
                    begin
                        page_valid_reg[own_rdata_reg[PIW-1:0]] <= 1'b0;
                        for (int i = 0; i < TLB_ENTRIES; i++)
                        begin
                            if (tlb_valid_reg[i] && (tlb_page_reg[i] == own_rdata_reg))
                            begin
                                tlb_valid_reg[i] <= 1'b0;
                                tlb_stamp_reg[i] <= '0;
                            end
                        end
                    end
                    page_valid_reg[pidx]          <= 1'b1;
                    owner_valid_reg[best_idx_reg] <= 1'b1;
                end
                OP_TSCAN:
                begin
                    if (tcnt_reg != TCW'(TLB_ENTRIES))
                    begin
                        tcnt_reg <= tcnt_reg + 1'b1;
                    end
                end
                OP_REFILL:
                begin
                    tlb_valid_reg[tbest_idx_reg] <= 1'b1;
                    tlb_stamp_reg[tbest_idx_reg] <= clk_reg;
                end
                default:
                begin
                    clk_reg <= clk_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                off_reg  <= virtual_address[OFFSET_BITS-1:0];
                page_reg <= va_sh[PAGE_W-1:0];
            end
            OP_REDUCE:
            begin
                page_reg <= page_reg - PAGE_W'(PAGE_COUNT);
            end
            OP_LOOKUP:
            begin
                hit_reg   <= match;
                fault_reg <= !match && !page_valid_reg[pidx];
                hidx_reg  <= midx;
                frame_reg <= tlb_frame_reg[midx];
            end
            OP_PF_USE:
            begin
                frame_reg <= pf_rdata_reg;
            end
            OP_VSCAN:
            begin
                rd_idx_reg  <= vidx;
                fs_vbit_reg <= fs_valid_reg[vidx];
                // strict less-than keeps the lowest index on ties
                if (rd_vld_reg && ((rd_idx_reg == '0) || (fs_eff < best_stamp_reg)))
                begin
                    best_idx_reg   <= rd_idx_reg;
                    best_stamp_reg <= fs_eff;
                end
            end
            OP_OWN_RD:
            begin
                own_vld_reg <= owner_valid_reg[best_idx_reg];
            end
            OP_OWN_USE:
            begin
                frame_reg <= FRAME_W'(best_idx_reg);
            end
            OP_TSCAN:
            begin
                if (tcnt_reg != TCW'(TLB_ENTRIES))
                begin
                    if ((tidx == '0) || (tlb_stamp_reg[tidx] < tbest_stamp_reg))
                    begin
                        tbest_idx_reg   <= tidx;
                        tbest_stamp_reg <= tlb_stamp_reg[tidx];
                    end
                end
            end
            OP_REFILL:
            begin
                tlb_page_reg[tbest_idx_reg]  <= page_reg;
                tlb_frame_reg[tbest_idx_reg] <= frame_reg;
            end
            default:
            begin
                off_reg <= off_reg;
            end
        endcase
    end

    // page table memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OWN_USE)
        begin
            pf_mem[pidx] <= FRAME_W'(best_idx_reg);
        end
        if (cmd.op == OP_PF_RD)
        begin
            pf_rdata_reg <= pf_mem[pidx];
        end
    end

    // frame owner memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OWN_USE)
        begin
            owner_mem[best_idx_reg] <= page_reg;
        end
        if (cmd.op == OP_OWN_RD)
        begin
            own_rdata_reg <= owner_mem[best_idx_reg];
        end
    end

    // frame stamp memory
    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[fs_waddr] <= clk_reg;
        end
        if (cmd.op == OP_VSCAN)
        begin
            fs_rdata_reg <= fs_mem[vidx];
        end
    end

    // result fields
    assign pa_wide          = 32'({frame_reg, off_reg});
    assign physical_address = pa_wide[VA_W-1:0];
    assign frame_number     = frame_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;
    assign load_page        = page_reg;

endmodule

@@ bench/translator_checker.sv @@
// checker for the tlb / page table translator: watches both channels,
// predicts each translation and compares it; depends on tptl_pkg
module translator_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [tptl_pkg::VA_W-1:0]    virtual_address,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [tptl_pkg::VA_W-1:0]    physical_address,
    input  logic [tptl_pkg::FRAME_W-1:0] frame_number,
    input  logic                         tlb_hit,
    input  logic                         page_fault,
    input  logic [tptl_pkg::PAGE_W-1:0]  load_page,
    output int                           fail_count,
    output int                           pending_count,
    output int                           hit_total,
    output int                           fault_total
);
    import tptl_pkg::*;

    localparam int TLBN = TLB_ENTRIES_DEF;
    localparam int PGN  = PAGE_COUNT_DEF;
    localparam int FRN  = FRAME_COUNT_DEF;
    localparam int OFFB = OFFSET_BITS_DEF;

    typedef struct packed {
        logic [VA_W-1:0]    pa;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               fault;
        logic [PAGE_W-1:0]  page;
    } xlat_t;

    // shadow copy of the translator state
    logic [PAGE_W-1:0]  sh_tlb_page [TLBN];
    logic [FRAME_W-1:0] sh_tlb_frame[TLBN];
    logic               sh_tlb_valid[TLBN];
    logic [31:0]        sh_tlb_stamp[TLBN];
    logic [FRAME_W-1:0] sh_page_frame[PGN];
    logic               sh_page_valid[PGN];
    logic [8:0]         sh_owner[FRN];
    logic [31:0]        sh_frame_stamp[FRN];
    logic [31:0]        sh_clock;

    xlat_t expected_xlats[$];

    // refill the least recently used tlb entry
    function automatic void fill_tlb(input int page, input int frame);
        int best;
        best = 0;
        for (int i = 1; i < TLBN; i++)
            if (sh_tlb_stamp[i] < sh_tlb_stamp[best])
                best = i;
        sh_tlb_page[best]  = PAGE_W'(page);
        sh_tlb_frame[best] = FRAME_W'(frame);
        sh_tlb_valid[best] = 1'b1;
        sh_tlb_stamp[best] = sh_clock;
    endfunction

    // translate one address and update the shadow state
    function automatic xlat_t translate(input logic [VA_W-1:0] va);
        xlat_t r;
        int offset, page, frame, old, best;
        logic hit, fault;
        offset = va & ((1 << OFFB) - 1);
        page   = ((va >> OFFB) & 8'hff) % PGN;
        frame  = 0;
        hit    = 1'b0;
        fault  = 1'b0;
        if (sh_clock != 32'hffff_ffff)
            sh_clock++;
        for (int i = 0; i < TLBN; i++)
        begin
            if (!hit && sh_tlb_valid[i] && sh_tlb_page[i] == page)
            begin
                hit = 1'b1;
                sh_tlb_stamp[i] = sh_clock;
                frame = sh_tlb_frame[i] % FRN;
                sh_frame_stamp[frame] = sh_clock;
            end
        end
        if (!hit && sh_page_valid[page])
        begin
            frame = sh_page_frame[page] % FRN;
            fill_tlb(page, frame);
            sh_frame_stamp[frame] = sh_clock;
        end
        else if (!hit)
        begin
            fault = 1'b1;
            best = 0;
            for (int i = 1; i < FRN; i++)
                if (sh_frame_stamp[i] < sh_frame_stamp[best])
                    best = i;
            frame = best;
            if (sh_owner[frame] != 0)
            begin
                old = (sh_owner[frame] - 1) % PGN;
                sh_page_valid[old] = 1'b0;
                for (int i = 0; i < TLBN; i++)
                    if (sh_tlb_valid[i] && sh_tlb_page[i] == old)
                    begin
                        sh_tlb_valid[i] = 1'b0;
                        sh_tlb_stamp[i] = '0;
                    end
            end
            sh_owner[frame] = 9'(page + 1);
            sh_frame_stamp[frame] = sh_clock;
            sh_page_frame[page] = FRAME_W'(frame);
            sh_page_valid[page] = 1'b1;
            fill_tlb(page, frame);
        end
        r.pa    = VA_W'(((frame << OFFB) | offset) & 16'hffff);
        r.frame = FRAME_W'(frame);
        r.hit   = hit;
        r.fault = fault;
        r.page  = PAGE_W'(page);
        return r;
    endfunction

    // watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        xlat_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < TLBN; i++)
            begin
                sh_tlb_page[i] = '0; sh_tlb_frame[i] = '0;
                sh_tlb_valid[i] = 1'b0; sh_tlb_stamp[i] = '0;
            end
            for (int i = 0; i < PGN; i++)
            begin
                sh_page_frame[i] = '0; sh_page_valid[i] = 1'b0;
            end
            for (int i = 0; i < FRN; i++)
            begin
                sh_owner[i] = '0; sh_frame_stamp[i] = '0;
            end
            sh_clock = '0;
            expected_xlats.delete();
            fail_count = 0;
            pending_count = 0;
            hit_total = 0;
            fault_total = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_xlats.size() == 0)
                begin
                    $error("result transaction with no translation pending");
                    fail_count++;
                end
                else
                begin
                    e = expected_xlats.pop_front();
                    if (physical_address !== e.pa)
                    begin
                        $error("physical_address expected %h actual %h", e.pa, physical_address);
                        fail_count++;
                    end
                    if (frame_number !== e.frame)
                    begin
                        $error("frame_number expected %h actual %h", e.frame, frame_number);
                        fail_count++;
                    end
                    if (tlb_hit !== e.hit)
                    begin
                        $error("tlb_hit expected %b actual %b", e.hit, tlb_hit);
                        fail_count++;
                    end
                    if (page_fault !== e.fault)
                    begin
                        $error("page_fault expected %b actual %b", e.fault, page_fault);
                        fail_count++;
                    end
                    if (load_page !== e.page)
                    begin
                        $error("load_page expected %h actual %h", e.page, load_page);
                        fail_count++;
                    end
                    hit_total += e.hit;
                    fault_total += e.fault;
                end
            end
            if (in_valid && !in_stall)
                expected_xlats.push_back(translate(virtual_address));
            pending_count = expected_xlats.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
// stimulus and verdict for the tlb / page table translator
// depends on tptl_pkg, the translator rtl and translator_checker
module testbench;
    import tptl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [VA_W-1:0]   virtual_address = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [VA_W-1:0]   physical_address;
    logic [FRAME_W-1:0] frame_number;
    logic              tlb_hit;
    logic              page_fault;
    logic [PAGE_W-1:0] load_page;
    int                fail_count, pending_count, hit_total, fault_total;
    int                sent_count = 0;
    int                idle_cycles = 0;
    bit                calm_phase = 1'b0;
    bit                hold_receiver = 1'b0;
    logic [PAGE_W-1:0] hot_pages[8];

    always #5 clk = ~clk;

    tlb_page_table_lru_translator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .virtual_address(virtual_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .physical_address(physical_address), .frame_number(frame_number),
        .tlb_hit(tlb_hit), .page_fault(page_fault), .load_page(load_page)
    );

    translator_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .virtual_address(virtual_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .physical_address(physical_address), .frame_number(frame_number),
        .tlb_hit(tlb_hit), .page_fault(page_fault), .load_page(load_page),
        .fail_count(fail_count), .pending_count(pending_count),
        .hit_total(hit_total), .fault_total(fault_total)
    );

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall in bursts, or a long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (600) @(negedge clk);
                out_stall <= 1'b0;
                wait (!hold_receiver);
            end
            else if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one address and hold it until accepted
    task automatic send_address(input logic [VA_W-1:0] va);
        int n;
        if (!calm_phase && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        virtual_address <= va;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent_count++;
    endtask

    // address on a page from a small hot set, random offset
    function automatic logic [VA_W-1:0] hot_address();
        return {hot_pages[$urandom_range(0, 7)], 8'($urandom)};
    endfunction

    initial
    begin
        logic [VA_W-1:0] va;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, repeat hits, page table hits after tlb eviction
        send_address(16'h0000);
        send_address(16'hffff);
        send_address(16'h00ff);
        send_address(16'hff00);
        send_address(16'h0000);
        send_address(16'h5aa5);
        send_address(16'ha55a);
        for (int p = 1; p <= 17; p++)
            send_address({8'(p * 3), 8'(p * 15)});
        send_address(16'h0312);
        in_valid <= 1'b0;

        // sender pauses until every translation has come back
        wait (pending_count == 0);
        @(negedge clk);

        // long receiver hold-off while the sender keeps offering
        hold_receiver = 1'b1;
        for (int i = 0; i < 5; i++)
            send_address(16'($urandom));
        hold_receiver = 1'b0;

        // random: half reuse of a hot set, some low pages, churn of the full space for evictions
        for (int k = 0; k < 8; k++)
            hot_pages[k] = 8'($urandom);
        for (int i = 0; i < 1420; i++)
        begin
            if (i == 1250)
                calm_phase = 1'b1;
            if (i % 200 == 0)
                hot_pages[$urandom_range(0, 7)] = 8'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: va = hot_address();
                5, 6: va = {8'($urandom_range(0, 31)), 8'($urandom)};
                default: va = 16'($urandom);
            endcase
            send_address(va);
        end
        in_valid <= 1'b0;

        wait (pending_count == 0);
        repeat (300) @(negedge clk);
        $display("translated %0d addresses: %0d tlb hits, %0d page faults",
                 sent_count, hit_total, fault_total);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
